// ===== src/kpec_pkg.sv =====
// kpec_pkg: shared types, operation codes, flag masks and register reset values
// for the key press event classifier; depends on nothing
package kpec_pkg;

   // operation codes of the func field
   localparam logic [3:0] FUNC_SCAN       = 4'd0;
   localparam logic [3:0] FUNC_SHORT      = 4'd1;
   localparam logic [3:0] FUNC_LONG       = 4'd2;
   localparam logic [3:0] FUNC_ONCE       = 4'd3;
   localparam logic [3:0] FUNC_PRESS      = 4'd4;
   localparam logic [3:0] FUNC_EDGE       = 4'd5;
   localparam logic [3:0] FUNC_EDGE_RISE  = 4'd6;
   localparam logic [3:0] FUNC_EDGE_FALL  = 4'd7;
   localparam logic [3:0] FUNC_CLEAR      = 4'd8;
   localparam logic [3:0] FUNC_EDGE_CLEAR = 4'd9;

   // answer codes
   localparam logic [1:0] ANS_NONE = 2'd0;
   localparam logic [1:0] ANS_YES  = 2'd1;
   localparam logic [1:0] ANS_RISE = 2'd1;
   localparam logic [1:0] ANS_FALL = 2'd2;

   // flag masks
   localparam logic [5:0] FLAG_SHORT = 6'h01;
   localparam logic [5:0] FLAG_LONG  = 6'h02;
   localparam logic [5:0] FLAG_ONCE  = 6'h04;
   localparam logic [5:0] FLAG_PRESS = 6'h08;
   localparam logic [5:0] FLAG_RISE  = 6'h10;
   localparam logic [5:0] FLAG_FALL  = 6'h20;
   localparam logic [5:0] FLAG_NONE  = 6'h00;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BIT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE  = 3'd4;

   // register reset values
   localparam logic [3:0] KEY_BIT_RESET  = 4'd0;
   localparam logic [7:0] DEBOUNCE_RESET = 8'd3;
   localparam logic [7:0] LONG_RESET     = 8'd100;
   localparam logic [7:0] CAP_RESET      = 8'd110;
   localparam logic [7:0] RELEASE_RESET  = 8'd2;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [3:0]  func;
      logic [15:0] pin_word;
   } req_type;

   typedef struct packed {
      logic [1:0] answer;
      logic [5:0] flags;
   } rsp_type;

   typedef struct packed {
      logic [3:0] key_bit;
      logic [7:0] debounce_ticks;
      logic [7:0] long_ticks;
      logic [7:0] count_cap;
      logic [7:0] release_ticks;
   } cfg_type;

endpackage

// ===== src/kpec_csr.sv =====
// kpec_csr: configuration registers of the key press event classifier
// depends on kpec_pkg
module kpec_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [kpec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata,
   output kpec_pkg::cfg_type                cfg
);

   kpec_pkg::cfg_type cfg_ff;
   kpec_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            kpec_pkg::CSR_KEY_BIT:  cfg_in.key_bit        = csr_wdata[3:0];
            kpec_pkg::CSR_DEBOUNCE: cfg_in.debounce_ticks = csr_wdata;
            kpec_pkg::CSR_LONG:     cfg_in.long_ticks     = csr_wdata;
            kpec_pkg::CSR_CAP:      cfg_in.count_cap      = csr_wdata;
            kpec_pkg::CSR_RELEASE:  cfg_in.release_ticks  = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bit        <= kpec_pkg::KEY_BIT_RESET;
         cfg_ff.debounce_ticks <= kpec_pkg::DEBOUNCE_RESET;
         cfg_ff.long_ticks     <= kpec_pkg::LONG_RESET;
         cfg_ff.count_cap      <= kpec_pkg::CAP_RESET;
         cfg_ff.release_ticks  <= kpec_pkg::RELEASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/kpec_core.sv =====
// kpec_core: press and release counters, event flags and the per-beat update
// depends on kpec_pkg
module kpec_core (
   input  logic               clock,
   input  logic               reset,
   input  kpec_pkg::cfg_type  cfg,
   input  logic               step_en,
   input  kpec_pkg::req_type  req,
   output kpec_pkg::rsp_type  rsp
);

   logic [7:0] press_count_ff, press_count_in;
   logic [7:0] release_count_ff, release_count_in;
   logic [5:0] flags_ff, flags_in;
   logic [1:0] answer;
   logic       pressed;
   logic [7:0] press_bumped;
   logic [7:0] release_bumped;

   function automatic logic [7:0] bump(input logic [7:0] c, input logic [7:0] cap);
      if (c <= cap && c < kpec_pkg::COUNT_MAX) begin
         return c + 8'd1;
      end
      return c;
   endfunction

   assign pressed        = ~req.pin_word[cfg.key_bit];
   assign press_bumped   = bump(press_count_ff, cfg.count_cap);
   assign release_bumped = bump(release_count_ff, cfg.count_cap);

   always_comb begin
      flags_in         = flags_ff;
      press_count_in   = press_count_ff;
      release_count_in = release_count_ff;
      answer           = kpec_pkg::ANS_NONE;
      case (req.func)
         kpec_pkg::FUNC_SCAN: begin
            if (pressed) begin
               if (press_count_ff == cfg.debounce_ticks) begin
                  flags_in = flags_in | kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_ONCE;
               end
               if (press_count_ff >= cfg.debounce_ticks) begin
                  flags_in = flags_in | kpec_pkg::FLAG_PRESS;
               end
               if (press_count_ff >= cfg.long_ticks) begin
                  flags_in = flags_in | kpec_pkg::FLAG_LONG;
               end
               press_count_in   = press_bumped;
               release_count_in = 8'd0;
            end else begin
               flags_in = flags_ff & (kpec_pkg::FLAG_ONCE | kpec_pkg::FLAG_RISE |
                                      kpec_pkg::FLAG_FALL);
               if (press_count_ff > cfg.debounce_ticks && press_count_ff < cfg.long_ticks) begin
                  flags_in = flags_in | kpec_pkg::FLAG_SHORT;
               end
               press_count_in   = 8'd0;
               release_count_in = release_bumped;
               if (release_bumped == cfg.release_ticks) begin
                  flags_in = flags_in | kpec_pkg::FLAG_FALL;
               end
            end
         end
         kpec_pkg::FUNC_SHORT: begin
            if ((flags_ff & kpec_pkg::FLAG_SHORT) != kpec_pkg::FLAG_NONE) begin
               flags_in = kpec_pkg::FLAG_NONE;
               answer   = kpec_pkg::ANS_YES;
            end
         end
         kpec_pkg::FUNC_LONG: begin
            if ((flags_ff & kpec_pkg::FLAG_LONG) != kpec_pkg::FLAG_NONE) begin
               answer = kpec_pkg::ANS_YES;
            end
         end
         kpec_pkg::FUNC_ONCE: begin
            if ((flags_ff & (kpec_pkg::FLAG_ONCE | kpec_pkg::FLAG_RISE |
                             kpec_pkg::FLAG_FALL)) != kpec_pkg::FLAG_NONE) begin
               flags_in = kpec_pkg::FLAG_NONE;
               answer   = kpec_pkg::ANS_YES;
            end
         end
         kpec_pkg::FUNC_PRESS: begin
            if ((flags_ff & kpec_pkg::FLAG_PRESS) != kpec_pkg::FLAG_NONE) begin
               answer = kpec_pkg::ANS_YES;
            end
         end
         kpec_pkg::FUNC_EDGE: begin
            if ((flags_ff & kpec_pkg::FLAG_RISE) != kpec_pkg::FLAG_NONE) begin
               answer = kpec_pkg::ANS_RISE;
            end else if ((flags_ff & kpec_pkg::FLAG_FALL) != kpec_pkg::FLAG_NONE) begin
               answer = kpec_pkg::ANS_FALL;
            end
         end
         kpec_pkg::FUNC_EDGE_RISE: begin
            if ((flags_ff & kpec_pkg::FLAG_RISE) != kpec_pkg::FLAG_NONE) begin
               flags_in = flags_ff & ~(kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_FALL);
               answer   = kpec_pkg::ANS_YES;
            end
         end
         kpec_pkg::FUNC_EDGE_FALL: begin
            if ((flags_ff & kpec_pkg::FLAG_FALL) != kpec_pkg::FLAG_NONE) begin
               flags_in = flags_ff & ~(kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_FALL);
               answer   = kpec_pkg::ANS_YES;
            end
         end
         kpec_pkg::FUNC_CLEAR: begin
            flags_in         = kpec_pkg::FLAG_NONE;
            press_count_in   = 8'd0;
            release_count_in = 8'd0;
         end
         kpec_pkg::FUNC_EDGE_CLEAR: begin
            flags_in = flags_ff & ~(kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_FALL);
         end
         default: begin
            answer = kpec_pkg::ANS_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_count_ff   <= 8'd0;
         release_count_ff <= 8'd0;
         flags_ff         <= kpec_pkg::FLAG_NONE;
      end else if (step_en) begin
         press_count_ff   <= press_count_in;
         release_count_ff <= release_count_in;
         flags_ff         <= flags_in;
      end
   end

   assign rsp.answer = answer;
   assign rsp.flags  = flags_in;

endmodule

// ===== src/key_press_event_classifier.sv =====
// key_press_event_classifier: top level with input and result registers
// depends on kpec_pkg, kpec_csr and kpec_core
//
// One beat is taken every clock cycle unless a waiting result stalls the input. An
// accepted beat lands in the input register; when it advances, the counters and flags
// are updated from it and its result is written to the result register in the same
// cycle. The single state update per cycle in the core sets the rate of one beat a
// cycle. The result register frees as it is taken; while a result waits, one more beat
// can enter the input register and the input then stalls until the result is taken.
// Configuration writes land immediately and should be issued only while no beat is in
// flight.
module key_press_event_classifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  kpec_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output kpec_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [kpec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);

   kpec_pkg::cfg_type cfg;
   kpec_pkg::req_type req_ff;
   kpec_pkg::rsp_type rsp_ff;
   kpec_pkg::rsp_type step_rsp;
   logic              in_valid_ff;
   logic              rsp_valid_ff;
   logic              advance;

   kpec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kpec_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .req     (req_ff),
      .rsp     (step_rsp)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_fills_input : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted beat missing from input register");

   a_advance_fills_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat missing from result register");

   a_answer_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.answer != 2'd3))
      else $error("undefined answer code");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!in_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

// ===== test/testbench.sv =====
// testbench: random and directed test of key_press_event_classifier with a
// scoreboard class that predicts answer and flags for every accepted beat
// depends on kpec_pkg and the key_press_event_classifier rtl
module testbench;

   localparam logic [3:0] FUNC_TOP = 4'd15;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS = 166;

   class press_scoreboard;
      logic [3:0]        key_bit;
      logic [7:0]        debounce_ticks;
      logic [7:0]        long_ticks;
      logic [7:0]        count_cap;
      logic [7:0]        release_ticks;
      logic [7:0]        press_cnt;
      logic [7:0]        release_cnt;
      logic [5:0]        flags;
      kpec_pkg::rsp_type expected_q[$];
      int                errors;

      function new();
         key_bit = kpec_pkg::KEY_BIT_RESET;
         debounce_ticks = kpec_pkg::DEBOUNCE_RESET;
         long_ticks = kpec_pkg::LONG_RESET;
         count_cap = kpec_pkg::CAP_RESET;
         release_ticks = kpec_pkg::RELEASE_RESET;
         press_cnt = '0;
         release_cnt = '0;
         flags = kpec_pkg::FLAG_NONE;
         errors = 0;
      endfunction

      function void set_reg(logic [kpec_pkg::CSR_INDEX_W-1:0] idx, logic [7:0] data);
         case (idx)
            kpec_pkg::CSR_KEY_BIT:  key_bit = data[3:0];
            kpec_pkg::CSR_DEBOUNCE: debounce_ticks = data;
            kpec_pkg::CSR_LONG:     long_ticks = data;
            kpec_pkg::CSR_CAP:      count_cap = data;
            kpec_pkg::CSR_RELEASE:  release_ticks = data;
            default: ;
         endcase
      endfunction

      // counts stop one past the cap (at 255 when the cap is 255) and never wrap
      function logic [7:0] advance(logic [7:0] c);
         if (c <= count_cap && c != kpec_pkg::COUNT_MAX) return c + 8'd1;
         return c;
      endfunction

      function void scan_tick(logic [15:0] pins);
         if (pins[key_bit] == 1'b0) begin
            if (press_cnt == debounce_ticks)
               flags |= kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_ONCE;
            if (press_cnt >= debounce_ticks) flags |= kpec_pkg::FLAG_PRESS;
            if (press_cnt >= long_ticks) flags |= kpec_pkg::FLAG_LONG;
            press_cnt = advance(press_cnt);
            release_cnt = '0;
         end else begin
            flags &= kpec_pkg::FLAG_ONCE | kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_FALL;
            if (press_cnt > debounce_ticks && press_cnt < long_ticks)
               flags |= kpec_pkg::FLAG_SHORT;
            press_cnt = '0;
            release_cnt = advance(release_cnt);
            if (release_cnt == release_ticks) flags |= kpec_pkg::FLAG_FALL;
         end
      endfunction

      function void note_request(kpec_pkg::req_type beat);
         kpec_pkg::rsp_type want;
         logic [1:0]        ans;
         ans = kpec_pkg::ANS_NONE;
         case (beat.func)
            kpec_pkg::FUNC_SCAN: scan_tick(beat.pin_word);
            kpec_pkg::FUNC_SHORT: begin
               if ((flags & kpec_pkg::FLAG_SHORT) != kpec_pkg::FLAG_NONE) begin
                  flags = kpec_pkg::FLAG_NONE;
                  ans = kpec_pkg::ANS_YES;
               end
            end
            kpec_pkg::FUNC_LONG: begin
               if ((flags & kpec_pkg::FLAG_LONG) != kpec_pkg::FLAG_NONE)
                  ans = kpec_pkg::ANS_YES;
            end
            kpec_pkg::FUNC_ONCE: begin
               if ((flags & (kpec_pkg::FLAG_ONCE | kpec_pkg::FLAG_RISE |
                             kpec_pkg::FLAG_FALL)) != kpec_pkg::FLAG_NONE) begin
                  flags = kpec_pkg::FLAG_NONE;
                  ans = kpec_pkg::ANS_YES;
               end
            end
            kpec_pkg::FUNC_PRESS: begin
               if ((flags & kpec_pkg::FLAG_PRESS) != kpec_pkg::FLAG_NONE)
                  ans = kpec_pkg::ANS_YES;
            end
            kpec_pkg::FUNC_EDGE: begin
               if ((flags & kpec_pkg::FLAG_RISE) != kpec_pkg::FLAG_NONE)
                  ans = kpec_pkg::ANS_RISE;
               else if ((flags & kpec_pkg::FLAG_FALL) != kpec_pkg::FLAG_NONE)
                  ans = kpec_pkg::ANS_FALL;
            end
            kpec_pkg::FUNC_EDGE_RISE: begin
               if ((flags & kpec_pkg::FLAG_RISE) != kpec_pkg::FLAG_NONE) begin
                  flags &= ~(kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_FALL);
                  ans = kpec_pkg::ANS_YES;
               end
            end
            kpec_pkg::FUNC_EDGE_FALL: begin
               if ((flags & kpec_pkg::FLAG_FALL) != kpec_pkg::FLAG_NONE) begin
                  flags &= ~(kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_FALL);
                  ans = kpec_pkg::ANS_YES;
               end
            end
            kpec_pkg::FUNC_CLEAR: begin
               flags = kpec_pkg::FLAG_NONE;
               press_cnt = '0;
               release_cnt = '0;
            end
            kpec_pkg::FUNC_EDGE_CLEAR:
               flags &= ~(kpec_pkg::FLAG_RISE | kpec_pkg::FLAG_FALL);
            default: ;
         endcase
         want.answer = ans;
         want.flags = flags;
         expected_q.push_back(want);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(kpec_pkg::rsp_type got);
         kpec_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending: answer %0d flags %h",
                             got.answer, got.flags));
            return;
         end
         want = expected_q.pop_front();
         if (got.answer !== want.answer)
            report($sformatf("answer %0d, wanted %0d", got.answer, want.answer));
         if (got.flags !== want.flags)
            report($sformatf("flags %h, wanted %h", got.flags, want.flags));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   kpec_pkg::req_type                req_payload;
   logic                             rsp_valid;
   logic                             rsp_ready;
   kpec_pkg::rsp_type                rsp_payload;
   logic                             csr_we;
   logic [kpec_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [7:0]                       csr_wdata;

   press_scoreboard   sb = new();
   kpec_pkg::cfg_type cur_cfg;
   kpec_pkg::cfg_type phase_cfg[RANDOM_PHASES];
   bit                steady;
   int                beats_sent;
   int                rsp_count;

   key_press_event_classifier u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_payload);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
   end

   function int draw_gap();
      if (steady) return 0;
      return $urandom_range(0, 14);
   endfunction

   // random pin word with the selected key forced up or down
   function logic [15:0] pin_sample(bit down);
      logic [15:0] p;
      p = 16'($urandom);
      p[cur_cfg.key_bit] = ~down;
      return p;
   endfunction

   task send_beat(logic [3:0] op, logic [15:0] pins);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{func: op, pin_word: pins};
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task load_config(kpec_pkg::cfg_type c);
      logic [7:0] vals[5];
      vals[kpec_pkg::CSR_KEY_BIT] = {4'd0, c.key_bit};
      vals[kpec_pkg::CSR_DEBOUNCE] = c.debounce_ticks;
      vals[kpec_pkg::CSR_LONG] = c.long_ticks;
      vals[kpec_pkg::CSR_CAP] = c.count_cap;
      vals[kpec_pkg::CSR_RELEASE] = c.release_ticks;
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= kpec_pkg::CSR_INDEX_W'(i);
         csr_wdata <= vals[i];
         sb.set_reg(kpec_pkg::CSR_INDEX_W'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_cfg = c;
   endtask

   task maybe_query(int one_in);
      if ($urandom_range(1, one_in) == 1)
         send_beat(4'($urandom_range(kpec_pkg::FUNC_SHORT, kpec_pkg::FUNC_EDGE_CLEAR)),
                   16'($urandom));
   endtask

   task key_sequence();
      int hi;
      int press_len;
      int release_len;
      hi = (cur_cfg.debounce_ticks > cur_cfg.long_ticks) ?
           cur_cfg.debounce_ticks : cur_cfg.long_ticks;
      hi = hi + 3;
      if ($urandom_range(0, 5) == 0)
         press_len = $urandom_range(0, (hi > cur_cfg.count_cap + 3) ? hi : cur_cfg.count_cap + 3);
      else
         press_len = $urandom_range(0, (hi < 40) ? hi : 40);
      if ($urandom_range(0, 7) == 0)
         release_len = $urandom_range(0, cur_cfg.count_cap + 3);
      else
         release_len = $urandom_range(1, (cur_cfg.release_ticks < 37) ?
                                         cur_cfg.release_ticks + 3 : 40);
      for (int i = 0; i < press_len; i++) begin
         send_beat(kpec_pkg::FUNC_SCAN, pin_sample(1'b1));
         maybe_query((press_len > 60) ? 30 : 5);
      end
      for (int i = 0; i < release_len; i++) begin
         send_beat(kpec_pkg::FUNC_SCAN, pin_sample(1'b0));
         maybe_query((release_len > 60) ? 30 : 4);
      end
   endtask

   task random_phase(int target);
      while (beats_sent < target) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               send_beat(4'($urandom_range(kpec_pkg::FUNC_SCAN, FUNC_TOP)), 16'($urandom));
         end else begin
            key_sequence();
         end
      end
   endtask

   task directed_beats();
      send_beat(kpec_pkg::FUNC_SCAN, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_SCAN, 16'hFFFE);
      send_beat(kpec_pkg::FUNC_SCAN, 16'h0000);
      send_beat(kpec_pkg::FUNC_SCAN, 16'hFFFE);
      send_beat(kpec_pkg::FUNC_SCAN, 16'hFFFE);
      send_beat(kpec_pkg::FUNC_SCAN, 16'h7FFE);
      send_beat(kpec_pkg::FUNC_EDGE, 16'h0000);
      send_beat(kpec_pkg::FUNC_PRESS, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_LONG, 16'h0000);
      send_beat(kpec_pkg::FUNC_EDGE_RISE, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_ONCE, 16'h0000);
      send_beat(kpec_pkg::FUNC_SCAN, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_SCAN, 16'h0001);
      send_beat(kpec_pkg::FUNC_SCAN, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_EDGE, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_EDGE_FALL, 16'h0000);
      send_beat(kpec_pkg::FUNC_SHORT, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_SCAN, 16'hFFFE);
      send_beat(kpec_pkg::FUNC_EDGE_CLEAR, 16'h0000);
      send_beat(kpec_pkg::FUNC_CLEAR, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_EDGE_CLEAR + 4'd1, 16'h0000);
      send_beat(FUNC_TOP, 16'hFFFF);
      send_beat(kpec_pkg::FUNC_ONCE, 16'h0000);
      send_beat(kpec_pkg::FUNC_SHORT, 16'h0000);
   endtask

   // receiver: random stalls plus long hold-offs so the block backs up
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      rsp_count = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = (rsp_count % 600 == 300) ? 80 : draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rsp_count++;
      end
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      steady = 1'b0;
      beats_sent = 0;
      cur_cfg = '{key_bit: kpec_pkg::KEY_BIT_RESET,
                  debounce_ticks: kpec_pkg::DEBOUNCE_RESET,
                  long_ticks: kpec_pkg::LONG_RESET, count_cap: kpec_pkg::CAP_RESET,
                  release_ticks: kpec_pkg::RELEASE_RESET};
      phase_cfg[0] = '{key_bit: 4'd15, debounce_ticks: 8'd1, long_ticks: 8'd1,
                       count_cap: 8'd1, release_ticks: 8'd1};
      phase_cfg[1] = '{key_bit: 4'd0, debounce_ticks: 8'd254, long_ticks: 8'd254,
                       count_cap: 8'd254, release_ticks: 8'd254};
      phase_cfg[2] = '{key_bit: 4'd5, debounce_ticks: 8'd2, long_ticks: 8'd8,
                       count_cap: 8'd10, release_ticks: 8'd3};
      phase_cfg[3] = '{key_bit: 4'd9, debounce_ticks: 8'd3, long_ticks: 8'd20,
                       count_cap: 8'd255, release_ticks: 8'd4};
      for (int p = 4; p < RANDOM_PHASES; p++) begin
         phase_cfg[p].key_bit = 4'($urandom_range(0, 15));
         phase_cfg[p].debounce_ticks = 8'($urandom_range(1, 12));
         phase_cfg[p].long_ticks = 8'($urandom_range(1, 40));
         phase_cfg[p].count_cap = 8'($urandom_range(1, 60));
         phase_cfg[p].release_ticks = 8'($urandom_range(1, 12));
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed_beats();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         steady = 1'b0;
         load_config(phase_cfg[p]);
         random_phase(beats_sent + PHASE_BEATS);
      end
      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
